FILE: rtl/fcdma_pkg.sv
// Shared types and constants for the four-channel DMA controller.
package fcdma_pkg;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] SEL_SRC_LO = 3'd0;
    localparam logic [2:0] SEL_SRC_HI = 3'd1;
    localparam logic [2:0] SEL_DST_LO = 3'd2;
    localparam logic [2:0] SEL_DST_HI = 3'd3;
    localparam logic [2:0] SEL_COUNT  = 3'd4;
    localparam logic [2:0] SEL_CTRL   = 3'd5;

    localparam logic [1:0] MODE_INC   = 2'd0;
    localparam logic [1:0] MODE_DEC   = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    localparam logic [1:0] START_NOW    = 2'd0;
    localparam logic [1:0] START_VBLANK = 2'd1;
    localparam logic [1:0] START_HBLANK = 2'd2;

    localparam int FULL_COUNT_CHANNEL = 3;
    localparam logic [16:0] COUNT_FULL_ZERO  = 17'h10000;
    localparam logic [16:0] COUNT_SHORT_ZERO = 17'h04000;
    localparam logic [15:0] COUNT_SHORT_MASK = 16'h3fff;
    localparam logic [15:0] READ_UNMAPPED    = 16'hffff;

    // stored control bits are register bits 15:5
    localparam int CTL_DMODE_LO = 0;
    localparam int CTL_SMODE_LO = 2;
    localparam int CTL_REPEAT   = 4;
    localparam int CTL_WIDE     = 5;
    localparam int CTL_START_LO = 7;
    localparam int CTL_ENABLE   = 10;

    typedef struct packed {
        logic        wr;
        logic [2:0]  sel;
        logic [15:0] value;
        logic        grant;
        logic        vblank;
        logic        hblank;
    } t_chan_cmd;

    typedef struct packed {
        logic        req;
        logic        wide;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] rdata;
    } t_chan_stat;

endpackage

FILE: rtl/fcdma_chan.sv
// One DMA channel: its registers, start condition and address stepping.
module fcdma_chan #(
    parameter int CH_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcdma_pkg::t_chan_cmd  i_cmd,
    output fcdma_pkg::t_chan_stat o_stat
);

    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_cnt, n_cnt;
    logic [10:0] r_ctl, n_ctl;
    logic        r_run, n_run;
    logic [31:0] r_cur_src, n_cur_src;
    logic [31:0] r_cur_dst, n_cur_dst;
    logic [16:0] r_rem, n_rem;

    logic [16:0] load_val;
    logic [15:0] cnt_masked;
    logic [1:0]  dmode, smode, start;
    logic        wide;
    logic [16:0] rem_dec;

    function automatic logic [31:0] step_for(input logic [1:0] mode, input logic w);
        logic [31:0] unit;
        unit = w ? 32'd4 : 32'd2;
        unique case (mode)
            fcdma_pkg::MODE_DEC:   step_for = 32'd0 - unit;
            fcdma_pkg::MODE_FIXED: step_for = 32'd0;
            default:               step_for = unit;
        endcase
    endfunction

    assign dmode = r_ctl[fcdma_pkg::CTL_DMODE_LO +: 2];
    assign smode = r_ctl[fcdma_pkg::CTL_SMODE_LO +: 2];
    assign start = r_ctl[fcdma_pkg::CTL_START_LO +: 2];
    assign wide  = r_ctl[fcdma_pkg::CTL_WIDE];

    always_comb begin
        if (CH_IDX == fcdma_pkg::FULL_COUNT_CHANNEL) begin
            cnt_masked = r_cnt;
            load_val   = (cnt_masked == 16'd0) ? fcdma_pkg::COUNT_FULL_ZERO
                                               : {1'b0, cnt_masked};
        end else begin
            cnt_masked = r_cnt & fcdma_pkg::COUNT_SHORT_MASK;
            load_val   = (cnt_masked == 16'd0) ? fcdma_pkg::COUNT_SHORT_ZERO
                                               : {1'b0, cnt_masked};
        end
    end

    assign rem_dec = r_rem - 17'd1;

    always_comb begin
        logic start_ok;
        unique case (start)
            fcdma_pkg::START_NOW:    start_ok = 1'b1;
            fcdma_pkg::START_VBLANK: start_ok = i_cmd.vblank;
            fcdma_pkg::START_HBLANK: start_ok = i_cmd.hblank;
            default:                 start_ok = 1'b0;
        endcase
        o_stat.req  = r_ctl[fcdma_pkg::CTL_ENABLE] & (r_run | start_ok);
        o_stat.wide = wide;
        o_stat.src  = r_cur_src;
        o_stat.dst  = r_cur_dst;
        unique case (i_cmd.sel)
            fcdma_pkg::SEL_SRC_LO: o_stat.rdata = r_src[15:0];
            fcdma_pkg::SEL_SRC_HI: o_stat.rdata = r_src[31:16];
            fcdma_pkg::SEL_DST_LO: o_stat.rdata = r_dst[15:0];
            fcdma_pkg::SEL_DST_HI: o_stat.rdata = r_dst[31:16];
            fcdma_pkg::SEL_COUNT:  o_stat.rdata = r_cnt;
            fcdma_pkg::SEL_CTRL:   o_stat.rdata = {r_ctl, 5'b0};
            default:               o_stat.rdata = fcdma_pkg::READ_UNMAPPED;
        endcase
    end

    always_comb begin
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_ctl     = r_ctl;
        n_run     = r_run;
        n_cur_src = r_cur_src;
        n_cur_dst = r_cur_dst;
        n_rem     = r_rem;
        if (i_cmd.wr) begin
            unique case (i_cmd.sel)
                fcdma_pkg::SEL_SRC_LO: n_src[15:0]  = i_cmd.value;
                fcdma_pkg::SEL_SRC_HI: n_src[31:16] = i_cmd.value;
                fcdma_pkg::SEL_DST_LO: n_dst[15:0]  = i_cmd.value;
                fcdma_pkg::SEL_DST_HI: n_dst[31:16] = i_cmd.value;
                fcdma_pkg::SEL_COUNT:  n_cnt        = i_cmd.value;
                fcdma_pkg::SEL_CTRL: begin
                    n_ctl = i_cmd.value[15:5];
                    if (!r_ctl[fcdma_pkg::CTL_ENABLE] && i_cmd.value[15]) begin
                        n_cur_src = r_src;
                        n_cur_dst = r_dst;
                        n_rem     = load_val;
                    end
                    if (!r_ctl[fcdma_pkg::CTL_ENABLE] || !i_cmd.value[15]) begin
                        n_run = 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.grant) begin
            n_run     = 1'b1;
            n_cur_src = r_cur_src + step_for(smode, wide);
            n_cur_dst = r_cur_dst + step_for(dmode, wide);
            n_rem     = rem_dec;
            if (rem_dec == 17'd0) begin
                n_run = 1'b0;
                if (r_ctl[fcdma_pkg::CTL_REPEAT]) begin
                    n_rem = load_val;
                    if (dmode == fcdma_pkg::MODE_RELOAD) begin
                        n_cur_dst = r_dst;
                    end
                end else begin
                    n_ctl[fcdma_pkg::CTL_ENABLE] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src     <= '0;
            r_dst     <= '0;
            r_cnt     <= '0;
            r_ctl     <= '0;
            r_run     <= 1'b0;
            r_cur_src <= '0;
            r_cur_dst <= '0;
            r_rem     <= '0;
        end else begin
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_cnt     <= n_cnt;
            r_ctl     <= n_ctl;
            r_run     <= n_run;
            r_cur_src <= n_cur_src;
            r_cur_dst <= n_cur_dst;
            r_rem     <= n_rem;
        end
    end

endmodule

FILE: rtl/four_channel_dma_controller.sv
// Top level: channel array, priority pick, read mux and result register.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | i_valid / o_ready  | i_kind i_channel i_reg_select i_write_value
//          |                    | i_vblank i_hblank
//  out     | o_valid / i_ready  | o_read_data o_transfer_valid o_transfer_channel
//          |                    | o_transfer_source o_transfer_dest o_transfer_wide
//
// One item per cycle while o_ready is high; its result appears in the next cycle.
// Channel state updates at the accepting edge, the result is held in one output register.
// o_ready is low only while a result waits and i_ready is low.
// Synchronous active-low reset clears all channel registers and disables every channel.
module four_channel_dma_controller #(
    parameter int CHANNEL_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_channel,
    input  logic [2:0]  i_reg_select,
    input  logic [15:0] i_write_value,
    input  logic        i_vblank,
    input  logic        i_hblank,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_read_data,
    output logic        o_transfer_valid,
    output logic [1:0]  o_transfer_channel,
    output logic [31:0] o_transfer_source,
    output logic [31:0] o_transfer_dest,
    output logic        o_transfer_wide
);

    fcdma_pkg::t_chan_cmd  chan_cmd  [CHANNEL_COUNT];
    fcdma_pkg::t_chan_stat chan_stat [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] grant;
    logic accept;

    logic        r_valid, n_valid;
    logic [15:0] r_read_data, n_read_data;
    logic        r_xfer, n_xfer;
    logic [1:0]  r_xfer_ch, n_xfer_ch;
    logic [31:0] r_xfer_src, n_xfer_src;
    logic [31:0] r_xfer_dst, n_xfer_dst;
    logic        r_xfer_wide, n_xfer_wide;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic found;
        found = 1'b0;
        grant = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (!found && chan_stat[c].req) begin
                grant[c] = 1'b1;
                found    = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_chan
        always_comb begin
            chan_cmd[g].wr     = accept && (i_kind == fcdma_pkg::KIND_WRITE) &&
                                 ({1'b0, i_channel} == 3'(g));
            chan_cmd[g].sel    = i_reg_select;
            chan_cmd[g].value  = i_write_value;
            chan_cmd[g].grant  = accept && (i_kind == fcdma_pkg::KIND_TICK) && grant[g];
            chan_cmd[g].vblank = i_vblank;
            chan_cmd[g].hblank = i_hblank;
        end

        fcdma_chan #(
            .CH_IDX (g)
        ) u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (chan_cmd[g]),
            .o_stat  (chan_stat[g])
        );
    end

    always_comb begin
        n_valid     = r_valid;
        n_read_data = r_read_data;
        n_xfer      = r_xfer;
        n_xfer_ch   = r_xfer_ch;
        n_xfer_src  = r_xfer_src;
        n_xfer_dst  = r_xfer_dst;
        n_xfer_wide = r_xfer_wide;
        if (accept) begin
            n_valid     = 1'b1;
            n_read_data = '0;
            n_xfer      = 1'b0;
            n_xfer_ch   = '0;
            n_xfer_src  = '0;
            n_xfer_dst  = '0;
            n_xfer_wide = 1'b0;
            if (i_kind == fcdma_pkg::KIND_READ) begin
                n_read_data = fcdma_pkg::READ_UNMAPPED;
                for (int c = 0; c < CHANNEL_COUNT; c++) begin
                    if ({1'b0, i_channel} == 3'(c)) begin
                        n_read_data = chan_stat[c].rdata;
                    end
                end
            end else if (i_kind == fcdma_pkg::KIND_TICK) begin
                for (int c = 0; c < CHANNEL_COUNT; c++) begin
                    if (grant[c]) begin
                        n_xfer      = 1'b1;
                        n_xfer_ch   = 2'(c);
                        n_xfer_src  = chan_stat[c].src;
                        n_xfer_dst  = chan_stat[c].dst;
                        n_xfer_wide = chan_stat[c].wide;
                    end
                end
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_xfer      <= n_xfer;
        r_xfer_ch   <= n_xfer_ch;
        r_xfer_src  <= n_xfer_src;
        r_xfer_dst  <= n_xfer_dst;
        r_xfer_wide <= n_xfer_wide;
    end

    assign o_valid            = r_valid;
    assign o_read_data        = r_read_data;
    assign o_transfer_valid   = r_xfer;
    assign o_transfer_channel = r_xfer_ch;
    assign o_transfer_source  = r_xfer_src;
    assign o_transfer_dest    = r_xfer_dst;
    assign o_transfer_wide    = r_xfer_wide;

    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant))
        else $error("more than one channel granted");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item produced no result");

    a_no_xfer_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind != fcdma_pkg::KIND_TICK) |=> !o_transfer_valid)
        else $error("transfer issued on a register access");

    a_xfer_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_transfer_valid) |-> (o_read_data == 16'd0))
        else $error("read data set on a transfer result");

endmodule
